// File: hw/rtl/spsm_pkg.sv
package spsm_pkg;

    localparam int MAX_SOURCES = 8;
    localparam int NUM_STAGES  = MAX_SOURCES - 1;
    localparam int HALF_SHIFT  = 15;
    localparam int CUBE_SHIFT  = 31;

    localparam logic [3:0] MIN_SOURCES = 4'd2;
    localparam logic [3:0] THREE_WAY   = 4'd3;
    localparam logic [3:0] RESET_COUNT = 4'd2;
    localparam logic [3:0] COUNT_LIMIT = 4'(MAX_SOURCES);

    typedef logic signed [15:0] sample_t;

    typedef struct packed {
        sample_t sample_0;
        sample_t sample_1;
        sample_t sample_2;
        sample_t sample_3;
        sample_t sample_4;
        sample_t sample_5;
        sample_t sample_6;
        sample_t sample_7;
    } spsm_in_t;

    typedef struct packed {
        sample_t mixed_sample;
        logic    count_error;
    } spsm_out_t;

    typedef struct packed {
        logic                         valid;
        logic [3:0]                   count;
        logic                         err;
        sample_t                      acc;
        logic [MAX_SOURCES-1:0][15:0] samples;
    } spsm_stage_t;

    typedef struct packed {
        logic mix_en;
        logic force_en;
    } spsm_stage_ctl_t;

    function automatic logic is_pos(input sample_t v);
        is_pos = !v[15] && (v != 16'sd0);
    endfunction

    function automatic logic is_neg(input sample_t v);
        is_neg = v[15];
    endfunction

    // two-way mix; the product is only used when it is non-negative, so a shift truncates
    function automatic sample_t mix_two(input sample_t a, input sample_t b);
        logic signed [31:0] p;
        logic [15:0]        sh;
        logic [15:0]        s;
        p  = $signed({{16{a[15]}}, a}) * $signed({{16{b[15]}}, b});
        sh = p[HALF_SHIFT+15:HALF_SHIFT];
        s  = 16'(a) + 16'(b);
        if (is_pos(a) && is_pos(b))
        begin
            mix_two = sample_t'(s - sh);
        end
        else if (is_neg(a) && is_neg(b))
        begin
            mix_two = sample_t'(s + sh);
        end
        else
        begin
            mix_two = sample_t'(s);
        end
    endfunction

endpackage

// File: hw/rtl/spsm_mix_stage.sv
module spsm_mix_stage
    import spsm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  spsm_stage_t     stage_in,
    input  sample_t         sample_b,
    input  spsm_stage_ctl_t ctl,
    input  sample_t         force_val,
    output spsm_stage_t     stage_out
);

    logic        valid_reg;
    spsm_stage_t data_reg;
    spsm_stage_t data_next;

    always_comb
    begin
        data_next = stage_in;
        if (ctl.force_en)
        begin
            data_next.acc = force_val;
        end
        else if (ctl.mix_en)
        begin
            data_next.acc = mix_two(stage_in.acc, sample_b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule

// File: hw/rtl/spsm_three_lane.sv
module spsm_three_lane
    import spsm_pkg::*;
(
    input  logic    clk,
    input  sample_t a,
    input  sample_t b,
    input  sample_t c,
    output sample_t mix
);

    // first step: pairwise products and plain sums
    logic signed [31:0] prod_ab;
    logic signed [31:0] prod_ac;
    logic signed [31:0] prod_bc;

    logic [30:0] ab_mag_reg;
    logic [15:0] ab_sh_reg;
    logic [15:0] ac_sh_reg;
    logic [15:0] bc_sh_reg;
    logic [15:0] sum3_reg;
    sample_t     sum_ab_reg;
    sample_t     c_reg;
    logic        ab_same_reg;
    logic        all_same_reg;
    logic        neg_reg;

    always_comb
    begin
        prod_ab = $signed({{16{a[15]}}, a}) * $signed({{16{b[15]}}, b});
        prod_ac = $signed({{16{a[15]}}, a}) * $signed({{16{c[15]}}, c});
        prod_bc = $signed({{16{b[15]}}, b}) * $signed({{16{c[15]}}, c});
    end

    always_ff @(posedge clk)
    begin
        ab_mag_reg   <= prod_ab[30:0];
        ab_sh_reg    <= prod_ab[HALF_SHIFT+15:HALF_SHIFT];
        ac_sh_reg    <= prod_ac[HALF_SHIFT+15:HALF_SHIFT];
        bc_sh_reg    <= prod_bc[HALF_SHIFT+15:HALF_SHIFT];
        sum3_reg     <= 16'(a) + 16'(b) + 16'(c);
        sum_ab_reg   <= sample_t'(16'(a) + 16'(b));
        c_reg        <= c;
        ab_same_reg  <= (is_pos(a) && is_pos(b)) || (is_neg(a) && is_neg(b));
        all_same_reg <= (is_pos(a) && is_pos(b) && is_pos(c))
                     || (is_neg(a) && is_neg(b) && is_neg(c));
        neg_reg      <= is_neg(a);
    end

    // second step: cubic term and the candidate results
    logic [15:0] c_mag;
    logic [46:0] cube;
    logic [15:0] sq_sum;

    logic [15:0] cube_sh_reg;
    logic [15:0] base3_reg;
    logic [15:0] alt_pair_reg;
    sample_t     alt_split_reg;
    logic        ab_same2_reg;
    logic        all_same2_reg;
    logic        neg2_reg;

    always_comb
    begin
        c_mag  = neg_reg ? 16'(~c_reg + 16'sd1) : 16'(c_reg);
        cube   = 47'(ab_mag_reg) * 47'(c_mag);
        sq_sum = ab_sh_reg + ac_sh_reg + bc_sh_reg;
    end

    always_ff @(posedge clk)
    begin
        cube_sh_reg   <= cube[CUBE_SHIFT+15:CUBE_SHIFT];
        base3_reg     <= neg_reg ? (sum3_reg + sq_sum) : (sum3_reg - sq_sum);
        alt_pair_reg  <= neg_reg ? (sum3_reg + ab_sh_reg) : (sum3_reg - ab_sh_reg);
        alt_split_reg <= mix_two(sum_ab_reg, c_reg);
        ab_same2_reg  <= ab_same_reg;
        all_same2_reg <= all_same_reg;
        neg2_reg      <= neg_reg;
    end

    // cubic term mirrors in sign for the all-negative case
    always_comb
    begin
        if (all_same2_reg)
        begin
            mix = neg2_reg ? sample_t'(base3_reg - cube_sh_reg)
                           : sample_t'(base3_reg + cube_sh_reg);
        end
        else if (ab_same2_reg)
        begin
            mix = sample_t'(alt_pair_reg);
        end
        else
        begin
            mix = alt_split_reg;
        end
    end

endmodule

// File: hw/rtl/signed_pcm_soft_mixer_top.sv
// channel    | ports                         | transaction taken when
// -----------+-------------------------------+---------------------------
// input      | start, busy, samples          | start high, busy low
// result     | done, result                  | every cycle done is high
// config     | cfg_we, cfg_data              | cfg_we high
//
// seven-stage pipeline, one mix per stage; busy is never raised, so a new
// transaction can be taken every cycle
// a result shows up once its input transaction has passed every stage register, for one cycle
// the three-source path runs in a side lane that joins the chain at stage three
// reset clears the stage valid bits and sets the source count to two
// the receiver cannot stall, so nothing is held back
module signed_pcm_soft_mixer_top
    import spsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  spsm_in_t   samples,
    output logic       done,
    output spsm_out_t  result,
    input  logic       cfg_we,
    input  logic [3:0] cfg_data
);

    logic [3:0] count_reg;
    logic [3:0] count_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= RESET_COUNT;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_data;
        end
    end

    assign count_eff = (count_reg > COUNT_LIMIT) ? COUNT_LIMIT : count_reg;
    assign busy      = 1'b0;

    spsm_stage_t stage_head;
    spsm_stage_t stage_in_w [1:NUM_STAGES];
    spsm_stage_t stage_q    [1:NUM_STAGES];
    sample_t     three_mix;

    always_comb
    begin
        stage_head.valid      = start && !busy;
        stage_head.count      = count_eff;
        stage_head.err        = count_eff < MIN_SOURCES;
        stage_head.acc        = samples.sample_0;
        stage_head.samples[0] = samples.sample_0;
        stage_head.samples[1] = samples.sample_1;
        stage_head.samples[2] = samples.sample_2;
        stage_head.samples[3] = samples.sample_3;
        stage_head.samples[4] = samples.sample_4;
        stage_head.samples[5] = samples.sample_5;
        stage_head.samples[6] = samples.sample_6;
        stage_head.samples[7] = samples.sample_7;
    end

    spsm_three_lane u_three (
        .clk (clk),
        .a   (samples.sample_0),
        .b   (samples.sample_1),
        .c   (samples.sample_2),
        .mix (three_mix)
    );

    for (genvar k = 1; k <= NUM_STAGES; k++)
    begin : g_stage
        spsm_stage_ctl_t ctl;

        if (k == 1)
        begin : g_first
            assign stage_in_w[k] = stage_head;
        end
        else
        begin : g_rest
            assign stage_in_w[k] = stage_q[k-1];
        end

        // source k joins only when the count covers it; stage three takes the lane result when the count is three
        assign ctl.mix_en   = stage_in_w[k].count > 4'(k);
        assign ctl.force_en = (4'(k) == THREE_WAY) && (stage_in_w[k].count == THREE_WAY);

        spsm_mix_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (stage_in_w[k]),
            .sample_b  (sample_t'(stage_in_w[k].samples[k])),
            .ctl       (ctl),
            .force_val (three_mix),
            .stage_out (stage_q[k])
        );
    end

    assign done                = stage_q[NUM_STAGES].valid;
    assign result.count_error  = stage_q[NUM_STAGES].err;
    assign result.mixed_sample = stage_q[NUM_STAGES].err ? 16'sd0 : stage_q[NUM_STAGES].acc;

    a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        stage_q[NUM_STAGES].valid |-> $past(stage_q[NUM_STAGES-1].valid))
        else $error("last stage valid without a valid predecessor");

    a_count_carried: assert property (@(posedge clk) disable iff (!rst_n)
        stage_q[NUM_STAGES].valid |->
            stage_q[NUM_STAGES].count == $past(stage_q[NUM_STAGES-1].count))
        else $error("source count changed along the pipeline");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.count_error |-> result.mixed_sample == 16'sd0)
        else $error("error result carries a nonzero sample");

    a_err_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.count_error == (stage_q[NUM_STAGES].count < MIN_SOURCES))
        else $error("error flag disagrees with carried count");

endmodule
